[rtl/bba_pkg.sv]
// Shared types, codes and constants of the block bitmap allocator.
// Used by bba_scan_ctrl and block_bitmap_allocator_core; depends on nothing else.
`timescale 1ns / 1ps

package bba_pkg;

  // Defaults for the top-level parameters
  localparam int NUM_BLOCKS_DEF    = 16384;
  localparam int MAP_WORD_BITS_DEF = 32;

  // Fixed field widths
  localparam int TOTAL_W    = 15;
  localparam int BLK_ID_W   = 14;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 15;

  // Register reset values
  localparam logic [TOTAL_W-1:0]  TOTAL_BLOCKS_RST = 15'd16384;
  localparam logic [BLK_ID_W-1:0] FIRST_DATA_RST   = 14'd0;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_BLOCKS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_DATA   = 1'd1;

  // Opcodes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_SCAN,
    S_FREAD,
    S_FMOD,
    S_RESP
  } state_t;

  typedef struct packed {
    logic [TOTAL_W-1:0]  total_blocks;
    logic [BLK_ID_W-1:0] first_data_block;
  } cfg_t;

  typedef struct packed {
    logic [BLK_ID_W-1:0] granted_block;
    logic [STATUS_W-1:0] status;
  } res_t;

endpackage

[rtl/bba_map_ram.sv]
// Bitmap word store: one write port and one registered read port.
// Generic synchronous RAM; no package dependency.
`timescale 1ns / 1ps

module bba_map_ram #(
  parameter int DEPTH = 512,
  parameter int WIDTH = 32,
  parameter int AW    = 9
) (
  input  logic             clk,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/bba_scan_ctrl.sv]
// Sequencer of the allocator: clearing sweep, word/bit split of the start block,
// word scan and read-modify-write of the bitmap RAM. Depends on bba_pkg.
`timescale 1ns / 1ps

module bba_scan_ctrl #(
  parameter int NUM_BLOCKS    = bba_pkg::NUM_BLOCKS_DEF,
  parameter int MAP_WORD_BITS = bba_pkg::MAP_WORD_BITS_DEF,
  parameter int WORDS         = (NUM_BLOCKS + MAP_WORD_BITS - 1) / MAP_WORD_BITS,
  parameter int WW            = (WORDS > 1) ? $clog2(WORDS) : 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bba_pkg::cfg_t                 cfg,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_opcode,
  input  logic [bba_pkg::BLK_ID_W-1:0]  in_block_id,
  output logic                          res_valid,
  input  logic                          res_ready,
  output bba_pkg::res_t                 res,
  output logic                          mem_re,
  output logic [WW-1:0]                 mem_raddr,
  input  logic [MAP_WORD_BITS-1:0]      mem_rdata,
  output logic                          mem_we,
  output logic [WW-1:0]                 mem_waddr,
  output logic [MAP_WORD_BITS-1:0]      mem_wdata
);

  localparam int WB     = MAP_WORD_BITS;
  localparam int IW     = $clog2(WB);
  localparam int TW     = bba_pkg::TOTAL_W;
  localparam int BW     = bba_pkg::TOTAL_W + 1;
  // Reciprocal of the word width, exact for every TW-bit block number
  localparam int MW     = TW + 1;
  localparam int SH     = TW + IW;
  localparam int RECIP  = ((1 << SH) + WB - 1) / WB;
  localparam int PW     = TW + MW;
  localparam int NB_CLP = (NUM_BLOCKS > 32767) ? 32767 : NUM_BLOCKS;
  localparam logic [TW-1:0] LIM_MAX = TW'(NB_CLP);

  bba_pkg::state_t state_r, state_nxt;

  logic [WW-1:0]  clr_w_r, clr_w_nxt;
  logic           cnt_r, cnt_nxt;
  logic [BW-1:0]  orig_r, orig_nxt;
  logic           op_r, op_nxt;
  logic [WW-1:0]  word_r, word_nxt;
  logic [BW-1:0]  base_r, base_nxt;
  logic [IW-1:0]  bit_r, bit_nxt;
  logic           first_r, first_nxt;
  logic           more_r, more_nxt;
  logic           ck_vld_r, ck_vld_nxt;
  logic [WW-1:0]  ck_w_r, ck_w_nxt;
  logic [BW-1:0]  ck_base_r, ck_base_nxt;
  logic           ck_first_r, ck_first_nxt;
  bba_pkg::res_t  res_r, res_nxt;

  logic [TW-1:0]  lim;
  logic           range_empty;
  logic [PW-1:0]  div_prod;
  logic [BW-1:0]  word_base;
  logic [BW-1:0]  rd_left;
  logic [BW-1:0]  ck_left;
  logic [WB-1:0]  bit_ok;
  logic [WB-1:0]  avail;
  logic [IW-1:0]  hit_idx;

  // Scan limit and empty range
  assign lim = (cfg.total_blocks > LIM_MAX) ? LIM_MAX : cfg.total_blocks;
  assign range_empty = (lim == '0) || ({1'b0, cfg.first_data_block} >= lim);

  // Word index by reciprocal multiply, then first block of that word
  assign div_prod  = PW'(orig_r[TW-1:0]) * PW'(RECIP);
  assign word_base = BW'(word_r) * BW'(WB);

  // Blocks left below the limit from the issued and from the checked word
  assign rd_left = {1'b0, lim} - base_r;
  assign ck_left = {1'b0, lim} - ck_base_r;

  always_comb begin
    for (int i = 0; i < WB; i++) begin
      bit_ok[i] = (BW'(i) < ck_left) && (!ck_first_r || (IW'(i) >= bit_r));
    end
  end

  assign avail = ~mem_rdata & bit_ok;

  always_comb begin
    hit_idx = '0;
    for (int i = WB - 1; i >= 0; i--) begin
      if (avail[i]) begin
        hit_idx = IW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= bba_pkg::S_CLEAR;
      clr_w_r  <= '0;
      ck_vld_r <= 1'b0;
      more_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      clr_w_r  <= clr_w_nxt;
      ck_vld_r <= ck_vld_nxt;
      more_r   <= more_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    orig_r     <= orig_nxt;
    op_r       <= op_nxt;
    word_r     <= word_nxt;
    base_r     <= base_nxt;
    bit_r      <= bit_nxt;
    first_r    <= first_nxt;
    ck_w_r     <= ck_w_nxt;
    ck_base_r  <= ck_base_nxt;
    ck_first_r <= ck_first_nxt;
    res_r      <= res_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    clr_w_nxt    = clr_w_r;
    cnt_nxt      = cnt_r;
    orig_nxt     = orig_r;
    op_nxt       = op_r;
    word_nxt     = word_r;
    base_nxt     = base_r;
    bit_nxt      = bit_r;
    first_nxt    = first_r;
    more_nxt     = more_r;
    ck_vld_nxt   = 1'b0;
    ck_w_nxt     = ck_w_r;
    ck_base_nxt  = ck_base_r;
    ck_first_nxt = ck_first_r;
    res_nxt      = res_r;
    in_ready     = 1'b0;
    res_valid    = 1'b0;
    mem_re       = 1'b0;
    mem_raddr    = word_r;
    mem_we       = 1'b0;
    mem_waddr    = ck_w_r;
    mem_wdata    = mem_rdata;

    unique case (state_r)
      bba_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_w_r;
        mem_wdata = '0;
        clr_w_nxt = clr_w_r + 1'b1;
        if (clr_w_r == WW'(WORDS - 1)) begin
          state_nxt = bba_pkg::S_IDLE;
        end
      end

      bba_pkg::S_IDLE: begin
        in_ready = 1'b1;
        op_nxt   = in_opcode;
        cnt_nxt  = 1'b0;
        res_nxt.granted_block = '0;
        if (in_opcode == bba_pkg::OP_ALLOC) begin
          orig_nxt = {2'b00, cfg.first_data_block};
        end else begin
          orig_nxt = {2'b00, in_block_id};
        end
        if (in_valid) begin
          if (in_opcode == bba_pkg::OP_ALLOC) begin
            if (range_empty) begin
              res_nxt.status = bba_pkg::ST_FULL;
              state_nxt      = bba_pkg::S_RESP;
            end else begin
              state_nxt = bba_pkg::S_DIV;
            end
          end else begin
            if (({1'b0, in_block_id} >= lim) ||
                (in_block_id < cfg.first_data_block)) begin
              res_nxt.status = bba_pkg::ST_RANGE;
              state_nxt      = bba_pkg::S_RESP;
            end else begin
              state_nxt = bba_pkg::S_DIV;
            end
          end
        end
      end

      bba_pkg::S_DIV: begin
        // Word index first, then word base and bit offset
        cnt_nxt = 1'b1;
        if (!cnt_r) begin
          word_nxt = WW'(div_prod[PW-1:SH]);
        end else begin
          base_nxt = word_base;
          bit_nxt  = IW'(orig_r - word_base);
          if (op_r == bba_pkg::OP_ALLOC) begin
            first_nxt = 1'b1;
            more_nxt  = 1'b1;
            state_nxt = bba_pkg::S_SCAN;
          end else begin
            state_nxt = bba_pkg::S_FREAD;
          end
        end
      end

      bba_pkg::S_SCAN: begin
        // Issue side: one word read per cycle until the last word
        if (more_r) begin
          mem_re       = 1'b1;
          ck_vld_nxt   = 1'b1;
          ck_w_nxt     = word_r;
          ck_base_nxt  = base_r;
          ck_first_nxt = first_r;
          first_nxt    = 1'b0;
          more_nxt     = (rd_left > BW'(WB));
          word_nxt     = word_r + 1'b1;
          base_nxt     = base_r + BW'(WB);
        end
        // Check side: the word read in the previous cycle
        if (ck_vld_r) begin
          if (avail != '0) begin
            mem_we    = 1'b1;
            mem_waddr = ck_w_r;
            mem_wdata = mem_rdata | (WB'(1) << hit_idx);
            res_nxt.granted_block = bba_pkg::BLK_ID_W'(ck_base_r + BW'(hit_idx));
            res_nxt.status        = bba_pkg::ST_OK;
            more_nxt   = 1'b0;
            ck_vld_nxt = 1'b0;
            state_nxt  = bba_pkg::S_RESP;
          end else if (ck_left <= BW'(WB)) begin
            res_nxt.granted_block = '0;
            res_nxt.status        = bba_pkg::ST_FULL;
            more_nxt   = 1'b0;
            ck_vld_nxt = 1'b0;
            state_nxt  = bba_pkg::S_RESP;
          end
        end
      end

      bba_pkg::S_FREAD: begin
        mem_re    = 1'b1;
        mem_raddr = word_r;
        state_nxt = bba_pkg::S_FMOD;
      end

      bba_pkg::S_FMOD: begin
        mem_we    = 1'b1;
        mem_waddr = word_r;
        mem_wdata = mem_rdata & ~(WB'(1) << bit_r);
        res_nxt.granted_block = '0;
        res_nxt.status        = bba_pkg::ST_OK;
        state_nxt = bba_pkg::S_RESP;
      end

      bba_pkg::S_RESP: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = bba_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = bba_pkg::S_IDLE;
      end
    endcase
  end

  assign res = res_r;

endmodule

[rtl/block_bitmap_allocator_core.sv]
// Top level of the first-fit block bitmap allocator: configuration
// registers, output register, sequencer and bitmap RAM.
// Depends on bba_pkg, bba_scan_ctrl and bba_map_ram.
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid/in_ready): in_opcode 0 allocates the lowest free
//   block in [first_data_block, min(total_blocks, NUM_BLOCKS)); 1 frees
//   in_block_id. One result transfer on the output channel per request:
//   out_granted_block and out_status (ok, no free block, out of range).
//   Configuration: write cfg_wdata to register cfg_idx while cfg_we is high,
//   only while the block is idle. Index 0 total_blocks, 1 first_data_block.
// Operation
//   Requests are handled one at a time. A request that fails its range
//   check goes straight to its result. Otherwise the block number is first
//   split into word and bit by a reciprocal multiply; a free then reads the
//   word, writes it back and gives the result, an allocate scans the bitmap
//   words, one word per cycle through the RAM read port, until it finds a
//   free bit or reaches the limit, then gives the result.
// Reset
//   After rst_n the block sweeps every bitmap word of the RAM to all-free,
//   one word per cycle, with in_ready low.
// Stall
//   A result waits in the output register while out_ready is low; the next
//   request is still taken and processed, and holds at its result until the
//   output register frees up.

module block_bitmap_allocator_core #(
  parameter int NUM_BLOCKS    = bba_pkg::NUM_BLOCKS_DEF,
  parameter int MAP_WORD_BITS = bba_pkg::MAP_WORD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [bba_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [bba_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_opcode,
  input  logic [bba_pkg::BLK_ID_W-1:0]    in_block_id,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [bba_pkg::BLK_ID_W-1:0]    out_granted_block,
  output logic [bba_pkg::STATUS_W-1:0]    out_status
);

  localparam int WORDS = (NUM_BLOCKS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int WW    = (WORDS > 1) ? $clog2(WORDS) : 1;

  bba_pkg::cfg_t cfg_r, cfg_nxt;
  logic          out_valid_r, out_valid_nxt;
  bba_pkg::res_t out_res_r, out_res_nxt;

  logic                     res_valid;
  logic                     res_ready;
  bba_pkg::res_t            res;
  logic                     mem_re;
  logic [WW-1:0]            mem_raddr;
  logic [MAP_WORD_BITS-1:0] mem_rdata;
  logic                     mem_we;
  logic [WW-1:0]            mem_waddr;
  logic [MAP_WORD_BITS-1:0] mem_wdata;

  // Configuration registers
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        bba_pkg::REG_TOTAL_BLOCKS: cfg_nxt.total_blocks = cfg_wdata;
        bba_pkg::REG_FIRST_DATA: begin
          cfg_nxt.first_data_block = cfg_wdata[bba_pkg::BLK_ID_W-1:0];
        end
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  // Output register: load when empty or being drained, drop on transfer
  assign res_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.total_blocks     <= bba_pkg::TOTAL_BLOCKS_RST;
      cfg_r.first_data_block <= bba_pkg::FIRST_DATA_RST;
      out_valid_r            <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_granted_block = out_res_r.granted_block;
  assign out_status        = out_res_r.status;

  bba_scan_ctrl #(
    .NUM_BLOCKS    (NUM_BLOCKS),
    .MAP_WORD_BITS (MAP_WORD_BITS),
    .WORDS         (WORDS),
    .WW            (WW)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_opcode   (in_opcode),
    .in_block_id (in_block_id),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .mem_re      (mem_re),
    .mem_raddr   (mem_raddr),
    .mem_rdata   (mem_rdata),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata)
  );

  bba_map_ram #(
    .DEPTH (WORDS),
    .WIDTH (MAP_WORD_BITS),
    .AW    (WW)
  ) u_map (
    .clk   (clk),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata)
  );

endmodule

[tb/sv/testbench.sv]
// Self-checking bench for block_bitmap_allocator_core: first-fit allocate and free requests.
// Runs a directed table, then random phases under changing register settings.
// Depends on bba_pkg and the RTL top level.
`timescale 1ns / 1ps

module testbench;

  localparam int STORE_BLOCKS  = bba_pkg::NUM_BLOCKS_DEF;
  localparam int ITEM_TARGET   = 1170;
  localparam int IDLE_PCT      = 13;
  localparam int CALM_FROM     = 400;     // no idling on either side in this window
  localparam int CALM_TO       = 600;
  localparam int HOLD_AT       = 250;     // results seen before the long receiver hold
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 4;       // pause before a register write
  localparam int TAIL_CYCLES   = 40;
  localparam int STALL_LIMIT   = 5000;    // clear pass, full scan and long hold fit well inside

  typedef logic [bba_pkg::BLK_ID_W-1:0] blk_id_t;
  typedef logic [bba_pkg::TOTAL_W-1:0]  total_t;

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_we;
  logic [bba_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [bba_pkg::CFG_DATA_W-1:0] cfg_wdata;
  logic                           in_valid;
  logic                           in_ready;
  logic                           in_opcode;
  logic [bba_pkg::BLK_ID_W-1:0]   in_block_id;
  logic                           out_valid;
  logic                           out_ready;
  logic [bba_pkg::BLK_ID_W-1:0]   out_granted_block;
  logic [bba_pkg::STATUS_W-1:0]   out_status;

  block_bitmap_allocator_core u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_idx           (cfg_idx),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_opcode         (in_opcode),
    .in_block_id       (in_block_id),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_granted_block (out_granted_block),
    .out_status        (out_status)
  );

  // Shadow of the allocator: one bit per block plus both registers.
  bit                           used_map [0:STORE_BLOCKS-1];
  logic [bba_pkg::TOTAL_W-1:0]  cfg_total = bba_pkg::TOTAL_BLOCKS_RST;
  logic [bba_pkg::BLK_ID_W-1:0] cfg_first = bba_pkg::FIRST_DATA_RST;

  // Grants and status codes still owed by the block, oldest first.
  bba_pkg::res_t grant_queue [$];

  int  mismatches  = 0;
  int  items_sent  = 0;
  int  grants_seen = 0;
  int  quiet_count = 0;
  bit  calm        = 1'b0;
  bit  held_off    = 1'b0;

  // One row of the directed part: either a register write or a request.
  typedef struct {
    bit                             is_cfg;
    logic [bba_pkg::CFG_IDX_W-1:0]  reg_idx;
    logic [bba_pkg::CFG_DATA_W-1:0] reg_data;
    logic                           op;
    logic [bba_pkg::BLK_ID_W-1:0]   block;
    bit                             typed;
    bba_pkg::res_t                  want;
  } dir_row_t;

  dir_row_t dir_rows [$];

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Clamp the register to the store, then scan or clear one bit.
  function automatic bba_pkg::res_t first_fit_step(input logic op,
                                                   input logic [bba_pkg::BLK_ID_W-1:0] id);
    int            lim;
    bba_pkg::res_t r;
    lim = (cfg_total > STORE_BLOCKS) ? STORE_BLOCKS : cfg_total;
    r.granted_block = '0;
    if (op == bba_pkg::OP_ALLOC) begin
      r.status = bba_pkg::ST_FULL;
      for (int b = cfg_first; b < lim; b++) begin
        if (!used_map[b]) begin
          used_map[b]     = 1'b1;
          r.granted_block = b[bba_pkg::BLK_ID_W-1:0];
          r.status        = bba_pkg::ST_OK;
          break;
        end
      end
    end else if (id < cfg_first || id >= lim) begin
      r.status = bba_pkg::ST_RANGE;
    end else begin
      used_map[id] = 1'b0;
      r.status     = bba_pkg::ST_OK;
    end
    return r;
  endfunction

  function automatic dir_row_t cfg_row(input logic [bba_pkg::CFG_IDX_W-1:0] idx,
                                       input logic [bba_pkg::CFG_DATA_W-1:0] data);
    dir_row_t r;
    r = '{default: '0};
    r.is_cfg   = 1'b1;
    r.reg_idx  = idx;
    r.reg_data = data;
    return r;
  endfunction

  function automatic dir_row_t req_row(input logic op, input logic [bba_pkg::BLK_ID_W-1:0] id,
                                       input bit typed, input logic [bba_pkg::BLK_ID_W-1:0] g,
                                       input logic [bba_pkg::STATUS_W-1:0] s);
    dir_row_t r;
    r = '{default: '0};
    r.op                 = op;
    r.block              = id;
    r.typed              = typed;
    r.want.granted_block = g;
    r.want.status        = s;
    return r;
  endfunction

  task automatic note_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    mismatches++;
  endtask

  // Offer one request and hold it until the transfer; then log what it owes.
  task automatic send_request(input logic op, input logic [bba_pkg::BLK_ID_W-1:0] id,
                              input bit typed, input bba_pkg::res_t typed_res);
    bit            took;
    bba_pkg::res_t predicted;
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_opcode   <= op;
    in_block_id <= id;
    took = 1'b0;
    while (!took) begin
      // sample away from the edge, act on the edge
      @(negedge clk);
      took = in_ready;
      @(posedge clk);
    end
    predicted = first_fit_step(op, id);
    grant_queue.push_back(typed ? typed_res : predicted);
    items_sent++;
    calm = (items_sent >= CALM_FROM && items_sent < CALM_TO);
  endtask

  // Drain the block, then write one register.
  task automatic write_register(input logic [bba_pkg::CFG_IDX_W-1:0] idx,
                                input logic [bba_pkg::CFG_DATA_W-1:0] data);
    in_valid <= 1'b0;
    while (grant_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == bba_pkg::REG_TOTAL_BLOCKS) cfg_total = data;
    else cfg_first = data[bba_pkg::BLK_ID_W-1:0];
  endtask

  // Pick a window, then mix allocations with frees that mostly land inside it.
  task automatic run_random_phase(input int n);
    int                           lim;
    int                           lo;
    int                           width;
    int                           dice;
    logic [bba_pkg::TOTAL_W-1:0]  total;
    logic [bba_pkg::BLK_ID_W-1:0] first;
    logic                         op;
    logic [bba_pkg::BLK_ID_W-1:0] id;
    bba_pkg::res_t                none;
    none = '0;
    case ($urandom_range(9))
      0: begin
        // register above the store acts as the store size
        total = 15'h7FFF;
        first = blk_id_t'(STORE_BLOCKS - $urandom_range(1, 64));
      end
      1: begin
        total = total_t'(STORE_BLOCKS);
        first = '0;
      end
      2: begin
        total = total_t'($urandom_range(0, 8));
        first = blk_id_t'($urandom);
      end
      3: begin
        // empty window: first at the limit
        total = total_t'($urandom_range(1, STORE_BLOCKS - 1));
        first = total[bba_pkg::BLK_ID_W-1:0];
      end
      default: begin
        lim   = $urandom_range(1, STORE_BLOCKS);
        width = $urandom_range(1, 160);
        total = total_t'(lim);
        first = blk_id_t'((lim > width) ? lim - width : 0);
      end
    endcase
    write_register(bba_pkg::REG_TOTAL_BLOCKS, total);
    // the spare top bit of the data word must be dropped by the block
    write_register(bba_pkg::REG_FIRST_DATA, {1'($urandom_range(1)), first});
    lim = (cfg_total > STORE_BLOCKS) ? STORE_BLOCKS : cfg_total;
    lo  = cfg_first;
    for (int k = 0; k < n; k++) begin
      dice = $urandom_range(99);
      id   = blk_id_t'($urandom);
      op   = bba_pkg::OP_FREE;
      if (dice < 55) begin
        op = bba_pkg::OP_ALLOC;
      end else if (dice < 80 && lim > lo) begin
        if ($urandom_range(1))
          id = blk_id_t'($urandom_range(lo, (lim - 1 < lo + 63) ? lim - 1 : lo + 63));
        else id = blk_id_t'($urandom_range(lo, lim - 1));
      end else if (dice < 90) begin
        case ($urandom_range(3))
          0: id = blk_id_t'(lo - 1);
          1: id = blk_id_t'(lo);
          2: id = blk_id_t'(lim - 1);
          default: id = blk_id_t'(lim);
        endcase
      end
      send_request(op, id, 1'b0, none);
    end
  endtask

  // Stimulus: reset, directed table, random phases, drain, verdict.
  initial begin
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_idx     = bba_pkg::REG_TOTAL_BLOCKS;
    cfg_wdata   = '0;
    in_valid    = 1'b0;
    in_opcode   = bba_pkg::OP_ALLOC;
    in_block_id = '0;

    // defaults after reset: whole disk, first-fit from block zero
    dir_rows.push_back(req_row(bba_pkg::OP_ALLOC, 14'h3FFF, 1, 0, bba_pkg::ST_OK));
    dir_rows.push_back(req_row(bba_pkg::OP_ALLOC, 0, 1, 1, bba_pkg::ST_OK));
    dir_rows.push_back(req_row(bba_pkg::OP_ALLOC, 0, 1, 2, bba_pkg::ST_OK));
    dir_rows.push_back(req_row(bba_pkg::OP_FREE, 1, 1, 0, bba_pkg::ST_OK));
    dir_rows.push_back(req_row(bba_pkg::OP_ALLOC, 0, 0, 0, bba_pkg::ST_OK));
    dir_rows.push_back(req_row(bba_pkg::OP_FREE, 14'h3FFF, 1, 0, bba_pkg::ST_OK)); // already free
    dir_rows.push_back(req_row(bba_pkg::OP_FREE, 0, 1, 0, bba_pkg::ST_OK));
    // limit above the store, four blocks at the top, fill until full
    dir_rows.push_back(cfg_row(bba_pkg::REG_TOTAL_BLOCKS, 15'h7FFF));
    dir_rows.push_back(cfg_row(bba_pkg::REG_FIRST_DATA, 15'd16380));
    dir_rows.push_back(req_row(bba_pkg::OP_ALLOC, 0, 1, 16380, bba_pkg::ST_OK));
    dir_rows.push_back(req_row(bba_pkg::OP_ALLOC, 0, 1, 16381, bba_pkg::ST_OK));
    dir_rows.push_back(req_row(bba_pkg::OP_ALLOC, 0, 1, 16382, bba_pkg::ST_OK));
    dir_rows.push_back(req_row(bba_pkg::OP_ALLOC, 0, 1, 16383, bba_pkg::ST_OK));
    dir_rows.push_back(req_row(bba_pkg::OP_ALLOC, 0, 1, 0, bba_pkg::ST_FULL));
    dir_rows.push_back(req_row(bba_pkg::OP_FREE, 16379, 1, 0, bba_pkg::ST_RANGE));
    dir_rows.push_back(req_row(bba_pkg::OP_FREE, 16383, 1, 0, bba_pkg::ST_OK));
    dir_rows.push_back(req_row(bba_pkg::OP_ALLOC, 0, 0, 0, bba_pkg::ST_OK));
    // zero blocks: nothing to allocate, nothing to free
    dir_rows.push_back(cfg_row(bba_pkg::REG_TOTAL_BLOCKS, 15'd0));
    dir_rows.push_back(req_row(bba_pkg::OP_ALLOC, 0, 1, 0, bba_pkg::ST_FULL));
    dir_rows.push_back(req_row(bba_pkg::OP_FREE, 0, 1, 0, bba_pkg::ST_RANGE));
    // first data block above the limit
    dir_rows.push_back(cfg_row(bba_pkg::REG_TOTAL_BLOCKS, 15'd5));
    dir_rows.push_back(cfg_row(bba_pkg::REG_FIRST_DATA, 15'h400A));
    dir_rows.push_back(req_row(bba_pkg::OP_ALLOC, 0, 1, 0, bba_pkg::ST_FULL));
    dir_rows.push_back(req_row(bba_pkg::OP_FREE, 7, 1, 0, bba_pkg::ST_RANGE));
    // single block window
    dir_rows.push_back(cfg_row(bba_pkg::REG_TOTAL_BLOCKS, 15'd1));
    dir_rows.push_back(cfg_row(bba_pkg::REG_FIRST_DATA, 15'd0));
    dir_rows.push_back(req_row(bba_pkg::OP_ALLOC, 0, 1, 0, bba_pkg::ST_OK));
    dir_rows.push_back(req_row(bba_pkg::OP_ALLOC, 0, 1, 0, bba_pkg::ST_FULL));
    dir_rows.push_back(req_row(bba_pkg::OP_FREE, 1, 1, 0, bba_pkg::ST_RANGE));
    // last block only
    dir_rows.push_back(cfg_row(bba_pkg::REG_TOTAL_BLOCKS, 15'd16384));
    dir_rows.push_back(cfg_row(bba_pkg::REG_FIRST_DATA, 15'd16383));
    dir_rows.push_back(req_row(bba_pkg::OP_ALLOC, 0, 1, 0, bba_pkg::ST_FULL));
    dir_rows.push_back(req_row(bba_pkg::OP_FREE, 16383, 1, 0, bba_pkg::ST_OK));
    dir_rows.push_back(req_row(bba_pkg::OP_ALLOC, 14'h2AAA, 1, 16383, bba_pkg::ST_OK));
    dir_rows.push_back(cfg_row(bba_pkg::REG_TOTAL_BLOCKS, 15'd16383));
    dir_rows.push_back(req_row(bba_pkg::OP_FREE, 16383, 1, 0, bba_pkg::ST_RANGE));
    dir_rows.push_back(req_row(bba_pkg::OP_ALLOC, 0, 1, 0, bba_pkg::ST_FULL));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // the block sweeps its bitmap after reset; the handshake covers that
    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) write_register(dir_rows[i].reg_idx, dir_rows[i].reg_data);
      else send_request(dir_rows[i].op, dir_rows[i].block, dir_rows[i].typed,
                        dir_rows[i].want);
    end

    while (items_sent < ITEM_TARGET) run_random_phase($urandom_range(40, 90));

    in_valid <= 1'b0;
    while (grant_queue.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Receiver: random back-pressure, one long hold while the sender keeps offering.
  initial begin
    bit hold_now;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      hold_now = !held_off && grants_seen >= HOLD_AT && in_valid;
      @(posedge clk);
      if (hold_now) begin
        held_off = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Compare each result transfer against the oldest owed result; sample mid-cycle.
  always @(negedge clk) begin
    bba_pkg::res_t want;
    if (rst_n && out_valid && out_ready) begin
      grants_seen++;
      if (grant_queue.size() == 0) begin
        note_mismatch($sformatf("result %0d/%0d with no request pending",
                                out_granted_block, out_status));
      end else begin
        want = grant_queue.pop_front();
        if (out_granted_block !== want.granted_block)
          note_mismatch($sformatf("granted_block got %0d want %0d",
                                  out_granted_block, want.granted_block));
        if (out_status !== want.status)
          note_mismatch($sformatf("status got %0d want %0d", out_status, want.status));
      end
    end
  end

  // Watchdog: end the run when neither channel moves for too long.
  always @(negedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_count <= 0;
    end else begin
      quiet_count <= quiet_count + 1;
      if (quiet_count >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

endmodule

[sim.f]
rtl/bba_pkg.sv
rtl/bba_map_ram.sv
rtl/bba_scan_ctrl.sv
rtl/block_bitmap_allocator_core.sv
tb/sv/testbench.sv
